/* hw/rtl/srpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpp_pkg
// Shared types, register indexes and constants for the stepper speed to
// step-timer period converter.
// ----------------------------------------------------------------------------
package srpp_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MICROSTEPS    = 2'd0,
    REG_MAX_STEP_FREQ = 2'd1,
    REG_MIN_STEP_FREQ = 2'd2,
    REG_TICK_RATE     = 2'd3
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Field widths
  localparam int SPEED_W     = 16;
  localparam int MICROSTEP_W = 9;
  localparam int FREQ_W      = 16;
  localparam int TICK_W      = 24;
  localparam int TOP_W       = 16;
  localparam int RPM_W       = 16;

  // Register reset values
  localparam logic [MICROSTEP_W-1:0] MICROSTEPS_RST    = 9'd1;
  localparam logic [FREQ_W-1:0]      MAX_STEP_FREQ_RST = 16'd6900;
  localparam logic [FREQ_W-1:0]      MIN_STEP_FREQ_RST = 16'd40;
  localparam logic [TICK_W-1:0]      TICK_RATE_RST     = 24'd2000000;

  // speed * 200 * microsteps / (60 * 16) = speed * microsteps * 5 / 24.
  // The /8 is a shift, the /3 a reciprocal multiply that is exact for
  // any 25-bit operand.
  localparam int                 PROD_W      = SPEED_W + MICROSTEP_W;
  localparam int                 SCALED_W    = 25;
  localparam int                 DIV3_SHIFT  = 25;
  localparam logic [SCALED_W-1:0] DIV3_RECIP = 25'h0AAAAAB;
  localparam int                 RAW_FREQ_W  = 23;

  // Restoring dividers: one quotient bit per step
  localparam int DIVIDEND_W          = 24;
  localparam int DIVISOR_W           = 16;
  localparam int DIV_STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES          = DIVIDEND_W / DIV_STEPS_PER_STAGE;

  typedef struct packed {
    logic [DIVISOR_W-1:0]  rem;
    logic [DIVIDEND_W-1:0] dq;   // dividend bits shift out, quotient bits shift in
  } div_lane_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    div_lane_t         top;
    div_lane_t         rpm;
  } div_stage_t;

  // One restoring division step. A zero divisor yields all-ones quotient bits.
  function automatic div_lane_t div_step(div_lane_t lane, logic [DIVISOR_W-1:0] divisor);
    logic [DIVISOR_W:0] trial;
    div_lane_t          res;
    trial  = {lane.rem, lane.dq[DIVIDEND_W-1]};
    res.dq = {lane.dq[DIVIDEND_W-2:0], 1'b0};
    if (trial >= {1'b0, divisor}) begin
      res.rem   = DIVISOR_W'(trial - {1'b0, divisor});
      res.dq[0] = 1'b1;
    end else begin
      res.rem = trial[DIVISOR_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/stepper_rpm_to_pulse_period_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_rpm_to_pulse_period_core
// Converts a requested speed in 1/16 rpm to a clamped step frequency, a
// timer top and compare count, and the whole rpm achieved.
// ----------------------------------------------------------------------------
// Usage: one transaction enters per cycle unless a stall has backed up to
// the input, and results leave in order. Two 24-bit restoring dividers
// (timer top and achieved rpm) resolve three quotient bits per stage over
// eight stages; four stages of frequency arithmetic and one stage that loads
// the divider lanes come before them, and a saturation stage after. A
// stalled output backs up only through full stages, so bubbles are squeezed
// out.
// Configuration is applied directly and must be written while idle.
module stepper_rpm_to_pulse_period_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [srpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [srpp_pkg::SPEED_W-1:0]     speed_request,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [srpp_pkg::FREQ_W-1:0]      step_freq,
  output logic [srpp_pkg::TOP_W-1:0]       period_top,
  output logic [srpp_pkg::TOP_W-2:0]       compare_half,
  output logic [srpp_pkg::RPM_W-1:0]       actual_rpm
);
  import srpp_pkg::*;

  // Configuration registers
  logic [MICROSTEP_W-1:0] microsteps;
  logic [FREQ_W-1:0]      max_step_freq;
  logic [FREQ_W-1:0]      min_step_freq;
  logic [TICK_W-1:0]      tick_rate;
  logic [DIVISOR_W-1:0]   rpm_divisor;

  // Front stages
  logic                   s1_valid, s1_ready;
  logic [PROD_W-1:0]      s1_prod;
  logic                   s2_valid, s2_ready;
  logic [SCALED_W-1:0]    s2_scaled;
  logic                   s3_valid, s3_ready;
  logic [RAW_FREQ_W-1:0]  s3_raw;
  logic                   s4_valid, s4_ready;
  logic [FREQ_W-1:0]      s4_freq;
  logic                   s5_valid, s5_ready;
  div_stage_t             s5_data;

  logic [PROD_W+2:0]      times5;
  logic [2*SCALED_W-1:0]  recip_prod;
  logic [FREQ_W-1:0]      freq_capped;
  logic [FREQ_W+1:0]      freq_times3;

  // Divider stages
  logic                   div_valid [DIV_STAGES];
  logic                   div_ready [DIV_STAGES];
  div_stage_t             div_data  [DIV_STAGES];

  logic                   out_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      microsteps    <= MICROSTEPS_RST;
      max_step_freq <= MAX_STEP_FREQ_RST;
      min_step_freq <= MIN_STEP_FREQ_RST;
      tick_rate     <= TICK_RATE_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MICROSTEPS:    microsteps    <= cfg_data[MICROSTEP_W-1:0];
        REG_MAX_STEP_FREQ: max_step_freq <= cfg_data[FREQ_W-1:0];
        REG_MIN_STEP_FREQ: min_step_freq <= cfg_data[FREQ_W-1:0];
        REG_TICK_RATE:     tick_rate     <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Pulses per revolution over 60 seconds: 200 * microsteps / 60 = 10 * microsteps / 3
  assign rpm_divisor = DIVISOR_W'({microsteps, 3'b000}) + DIVISOR_W'({microsteps, 1'b0});

  // Stage handshake: a stage takes new data when empty or when it drains
  assign out_ready = !out_valid || !out_stall;
  assign s5_ready  = !s5_valid || div_ready[0];
  assign s4_ready  = !s4_valid || s5_ready;
  assign s3_ready  = !s3_valid || s4_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;

  // Stage 1: speed times microsteps
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_prod <= PROD_W'(speed_request) * PROD_W'(microsteps);
    end
  end

  // Stage 2: times five, divide by eight
  assign times5 = {3'b000, s1_prod} + {1'b0, s1_prod, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_scaled <= times5[PROD_W+2:3];
    end
  end

  // Stage 3: divide by three through the reciprocal
  assign recip_prod = (2*SCALED_W)'(s2_scaled) * (2*SCALED_W)'(DIV3_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
    if (s3_ready && s2_valid) begin
      s3_raw <= recip_prod[DIV3_SHIFT +: RAW_FREQ_W];
    end
  end

  // Stage 4: clamp to the maximum, then the minimum wins
  assign freq_capped = (s3_raw > RAW_FREQ_W'(max_step_freq)) ? max_step_freq
                                                             : s3_raw[FREQ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
    if (s4_ready && s3_valid) begin
      s4_freq <= (freq_capped < min_step_freq) ? min_step_freq : freq_capped;
    end
  end

  // Stage 5: load both divider lanes
  assign freq_times3 = {2'b00, s4_freq} + {1'b0, s4_freq, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_ready) begin
      s5_valid <= s4_valid;
    end
    if (s5_ready && s4_valid) begin
      s5_data.freq    <= s4_freq;
      s5_data.top.rem <= '0;
      s5_data.top.dq  <= DIVIDEND_W'(tick_rate);
      s5_data.rpm.rem <= '0;
      s5_data.rpm.dq  <= DIVIDEND_W'(freq_times3);
    end
  end

  // Divider stages: advance both quotients three bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic       prev_valid;
    div_stage_t prev_data;
    div_stage_t step_data;

    if (g == 0) begin : g_first
      assign prev_valid = s5_valid;
      assign prev_data  = s5_data;
    end else begin : g_rest
      assign prev_valid = div_valid[g-1];
      assign prev_data  = div_data[g-1];
    end

    if (g == DIV_STAGES - 1) begin : g_last_rdy
      assign div_ready[g] = !div_valid[g] || out_ready;
    end else begin : g_mid_rdy
      assign div_ready[g] = !div_valid[g] || div_ready[g+1];
    end

    always_comb begin
      step_data = prev_data;
      for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
        step_data.top = div_step(step_data.top, step_data.freq);
        step_data.rpm = div_step(step_data.rpm, rpm_divisor);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[g] <= 1'b0;
      end else if (div_ready[g]) begin
        div_valid[g] <= prev_valid;
      end
      if (div_ready[g] && prev_valid) begin
        div_data[g] <= step_data;
      end
    end
  end

  // Output stage: saturate quotients and hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= div_valid[DIV_STAGES-1];
    end
    if (out_ready && div_valid[DIV_STAGES-1]) begin
      step_freq <= div_data[DIV_STAGES-1].freq;
      if (|div_data[DIV_STAGES-1].top.dq[DIVIDEND_W-1:TOP_W]) begin
        period_top   <= '1;
        compare_half <= '1;
      end else begin
        period_top   <= div_data[DIV_STAGES-1].top.dq[TOP_W-1:0];
        compare_half <= div_data[DIV_STAGES-1].top.dq[TOP_W-1:1];
      end
      if (|div_data[DIV_STAGES-1].rpm.dq[DIVIDEND_W-1:RPM_W]) begin
        actual_rpm <= '1;
      end else begin
        actual_rpm <= div_data[DIV_STAGES-1].rpm.dq[RPM_W-1:0];
      end
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stepper speed to step-timer period converter.
// A queue-fed driver offers speed requests and a clocked monitor predicts each
// accepted transaction and compares every result field in order. The run moves
// through a directed pass and a series of random register settings. Both sides
// idle in random bursts, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import srpp_pkg::*;

  localparam longint unsigned FULL_STEPS   = 200;
  localparam longint unsigned SEC_PER_MIN  = 60;
  localparam int              SPEED_FRAC   = 4;
  localparam longint unsigned TOP_MAX      = (64'd1 << TOP_W) - 1;
  localparam longint unsigned RPM_MAX      = 65535;
  localparam int              RAND_PHASES  = 10;
  localparam int              PHASE_ITEMS  = 75;
  localparam int              DRAIN_CYCLES = 30;
  localparam int              LONG_HOLD    = 400;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [TOP_W-1:0]  top;
    logic [TOP_W-2:0]  half;
    logic [RPM_W-1:0]  rpm;
  } period_result_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_write     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic [SPEED_W-1:0]     speed_request = '0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic [FREQ_W-1:0]      step_freq;
  logic [TOP_W-1:0]       period_top;
  logic [TOP_W-2:0]       compare_half;
  logic [RPM_W-1:0]       actual_rpm;

  // Shadow copy of the configuration registers
  logic [MICROSTEP_W-1:0] reg_microsteps;
  logic [FREQ_W-1:0]      reg_max_freq;
  logic [FREQ_W-1:0]      reg_min_freq;
  logic [TICK_W-1:0]      reg_tick_rate;

  logic [SPEED_W-1:0] speed_backlog[$];
  period_result_t     expected_periods[$];
  int                 mismatch_count = 0;

  logic src_taken = 1'b0;
  int   src_gap   = 0;
  int   snk_gap   = 0;
  int   src_rate  = 0;
  int   snk_rate  = 0;
  logic hold_kick = 1'b0;
  int   hold_left = 0;

  stepper_rpm_to_pulse_period_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .speed_request(speed_request),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .step_freq    (step_freq),
    .period_top   (period_top),
    .compare_half (compare_half),
    .actual_rpm   (actual_rpm)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Compute the timer settings for one speed request under the shadow registers
  function automatic period_result_t predict_period(logic [SPEED_W-1:0] speed);
    longint unsigned ppr, freq, top, rpm;
    period_result_t  res;
    ppr  = FULL_STEPS * longint'(reg_microsteps);
    freq = (longint'(speed) * ppr) / (SEC_PER_MIN << SPEED_FRAC);
    if (freq > reg_max_freq) freq = reg_max_freq;
    if (freq < reg_min_freq) freq = reg_min_freq;
    if (freq == 0) begin
      top = TOP_MAX;
    end else begin
      top = reg_tick_rate / freq;
      if (top > TOP_MAX) top = TOP_MAX;
    end
    if (ppr == 0) begin
      rpm = RPM_MAX;
    end else begin
      rpm = (SEC_PER_MIN * freq) / ppr;
      if (rpm > RPM_MAX) rpm = RPM_MAX;
    end
    res.freq = freq[FREQ_W-1:0];
    res.top  = top[TOP_W-1:0];
    res.half = top[TOP_W-1:1];
    res.rpm  = rpm[RPM_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track register writes, predict accepted transactions, check results
  always @(posedge clk) begin
    period_result_t want;
    if (rst) begin
      reg_microsteps <= MICROSTEPS_RST;
      reg_max_freq   <= MAX_STEP_FREQ_RST;
      reg_min_freq   <= MIN_STEP_FREQ_RST;
      reg_tick_rate  <= TICK_RATE_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_MICROSTEPS:    reg_microsteps <= cfg_data[MICROSTEP_W-1:0];
          REG_MAX_STEP_FREQ: reg_max_freq   <= cfg_data[FREQ_W-1:0];
          REG_MIN_STEP_FREQ: reg_min_freq   <= cfg_data[FREQ_W-1:0];
          REG_TICK_RATE:     reg_tick_rate  <= cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_periods.push_back(predict_period(speed_request));
      if (out_valid && !out_stall) begin
        if (expected_periods.size() == 0) begin
          $display("%0t ns: unexpected result freq %0d top %0d", $time, step_freq, period_top);
          mismatch_count++;
        end else begin
          want = expected_periods.pop_front();
          check_field("step_freq", want.freq, step_freq);
          check_field("period_top", want.top, period_top);
          check_field("compare_half", want.half, compare_half);
          check_field("actual_rpm", want.rpm, actual_rpm);
        end
      end
    end
    src_taken <= in_valid && !in_stall;
  end

  // Feed speed requests from the backlog, holding each until it is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !src_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (speed_backlog.size() > 0) begin
        if (src_rate != 0 && $urandom_range(15, 0) < src_rate * 2) begin
          src_gap = $urandom_range(17, 1) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid      <= 1'b1;
          speed_request <= speed_backlog.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Count down the long output hold-off
  always @(negedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_kick) hold_left <= LONG_HOLD;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Stall the output in random bursts, or for the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (snk_gap > 0) snk_gap--;
      else if (snk_rate != 0 && $urandom_range(15, 0) < snk_rate * 2)
        snk_gap = $urandom_range(17, 1);
      out_stall <= (hold_left > 0) || (snk_gap > 0);
    end
  end

  // Wait until no transaction is pending or in flight
  task automatic wait_idle();
    while (speed_backlog.size() > 0 || in_valid || expected_periods.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  // Drain, then load all four registers
  task automatic load_regs(int ms, int fmax, int fmin, int tick);
    wait_idle();
    write_reg(REG_MICROSTEPS, CFG_DATA_W'(ms));
    write_reg(REG_MAX_STEP_FREQ, CFG_DATA_W'(fmax));
    write_reg(REG_MIN_STEP_FREQ, CFG_DATA_W'(fmin));
    write_reg(REG_TICK_RATE, CFG_DATA_W'(tick));
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int              ms, fmax, fmin, tick, waited;
    longint unsigned aim;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: clamp edges and field extremes under the reset settings
    speed_backlog = '{16'd0, 16'd1, 16'd4, 16'd5, 16'd191, 16'd192, 16'd193,
                      16'd33119, 16'd33120, 16'd33125, 16'h5555, 16'hAAAA, 16'hFFFF};
    // Zero microsteps: raw frequency is zero, achieved rpm saturates
    load_regs(0, 6900, 40, 2000000);
    speed_backlog = '{16'd0, 16'hFFFF};
    // Zero minimum: frequency can reach zero and the top saturates
    load_regs(1, 6900, 0, 2000000);
    speed_backlog = '{16'd0, 16'd4, 16'd5};
    load_regs(0, 6900, 0, 2000000);
    speed_backlog = '{16'hFFFF};
    // Crossed clamps: the minimum wins
    load_regs(1, 10, 100, 2000000);
    speed_backlog = '{16'd0, 16'hFFFF};
    // Widest settings, then the slowest tick
    load_regs(256, 65535, 1, 16000000);
    speed_backlog = '{16'd0, 16'd1, 16'hFFFF};
    load_regs(256, 65535, 1, 1);
    speed_backlog = '{16'hFFFF};

    // Random settings, each with a batch of random requests
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(9, 0))
        0:       ms = 0;
        1:       ms = 1;
        2:       ms = 256;
        default: ms = $urandom_range(256, 1);
      endcase
      case ($urandom_range(3, 0))
        0:       fmax = 65535;
        1:       fmax = 1;
        default: fmax = $urandom_range(65535, 1);
      endcase
      case ($urandom_range(7, 0))
        0:       fmin = 1;
        1:       fmin = 0;
        2:       fmin = 65535;
        default: fmin = $urandom_range(2000, 1);
      endcase
      case ($urandom_range(3, 0))
        0:       tick = 1;
        1:       tick = 16000000;
        default: tick = $urandom_range(16000000, 1);
      endcase
      load_regs(ms, fmax, fmin, tick);
      if (p == RAND_PHASES - 1) begin
        src_rate = 0;
        snk_rate = 0;
      end else begin
        src_rate = $urandom_range(3, 0);
        snk_rate = $urandom_range(3, 0);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(3, 0))
          0: speed_backlog.push_back(SPEED_W'($urandom_range(1023, 0)));
          1: begin
            // Aim near the upper clamp
            if (ms == 0) aim = $urandom_range(65535, 0);
            else aim = (longint'(fmax) * 960) / (FULL_STEPS * ms);
            aim = aim + $urandom_range(16, 0);
            aim = (aim > 8) ? aim - 8 : 0;
            if (aim > 65535) aim = 65535;
            speed_backlog.push_back(aim[SPEED_W-1:0]);
          end
          default: speed_backlog.push_back(SPEED_W'($urandom_range(65535, 0)));
        endcase
      end
      // Hold the output off while the driver keeps offering
      if (p == 1) begin
        hold_kick = 1'b1;
        @(posedge clk);
        hold_kick = 1'b0;
      end
    end

    // Drain and check for leftovers
    while (speed_backlog.size() > 0 || in_valid) @(posedge clk);
    waited = 0;
    while (expected_periods.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_periods.size() > 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_periods.size());
      mismatch_count++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

/* stepper_rpm_to_pulse_period_core.f */
hw/rtl/srpp_pkg.sv
hw/rtl/stepper_rpm_to_pulse_period_core.sv
dv/tb_top.sv
